// ===== rtl/core/sdff_pkg.sv =====
package sdff_pkg;

  localparam int MAX_DIGITS = 20;
  localparam int DIG_W      = 5;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [1:0] ARG_INT   = 2'd0;
  localparam logic [1:0] ARG_CHAR  = 2'd1;
  localparam logic [1:0] ARG_SHORT = 2'd2;
  localparam logic [1:0] ARG_LONG  = 2'd3;

  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_SPACE = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_PLAN = 5'b00100,
    ST_SPAN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  arg_size;
    logic [6:0]  width;
    logic        precision_given;
    logic [5:0]  precision;
    logic        zero_pad;
    logic        align_left;
    logic [1:0]  sign_mode;
  } req_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic plan;
    logic span;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic out_free;
    logic emit_last;
  } sts_t;

endpackage

// ===== rtl/core/sdff_ctrl.sv =====
module sdff_ctrl
  import sdff_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (sts.conv_done) begin
          state_next = ST_PLAN;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      ST_PLAN: begin
        cmd.plan   = 1'b1;
        state_next = ST_SPAN;
      end
      ST_SPAN: begin
        cmd.span   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/sdff_datapath.sv =====
module sdff_datapath
  import sdff_pkg::*;
#(
  parameter int MAX_FIELD = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  req_t        req,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        m_tready,
  output logic        m_tvalid,
  output logic [15:0] m_tdata,
  output logic        m_tlast,
  output logic        m_tuser
);

  localparam logic [7:0] FIELD8 = 8'(MAX_FIELD);
  localparam logic [6:0] FIELD7 = 7'(MAX_FIELD);

  logic [63:0]      mag_sr;
  logic [6:0]       cnt;
  logic [3:0]       bcd [MAX_DIGITS];
  logic [DIG_W-1:0] ndig;
  logic             neg;
  logic             pgiven;
  logic [5:0]       prec;
  logic             zpad;
  logic             left;
  logic [1:0]       smode;
  logic [6:0]       width;

  logic [DIG_W-1:0] dcnt;
  logic [5:0]       pz;
  logic             has_sign;
  logic [7:0]       sign_ch;
  logic [6:0]       wsat;
  logic             zf;

  logic [6:0]       total;
  logic [7:0]       e1;
  logic [7:0]       e2;
  logic [7:0]       e3;
  logic [7:0]       e4;
  logic [6:0]       pos;

  logic             m_valid_q;
  logic [7:0]       out_char;
  logic             out_flag;
  logic             out_last;
  logic [6:0]       out_total;

  logic [63:0]      sx;
  logic [63:0]      mag;
  logic [63:0]      mag_al;
  logic [6:0]       nbits;
  logic [3:0]       adj [MAX_DIGITS];
  logic [3:0]       dn [MAX_DIGITS];
  logic             ndig_inc;
  logic [DIG_W-1:0] d_cnt;
  logic [5:0]       d_pz;
  logic [7:0]       body;
  logic [7:0]       pad;
  logic [7:0]       sum;
  logic [7:0]       s_e1;
  logic [7:0]       s_e2;
  logic [7:0]       s_e3;
  logic [7:0]       pos8;
  logic [7:0]       didx8;
  logic [7:0]       ch;

  always_comb begin
    unique case (req.arg_size)
      ARG_INT: begin
        sx    = {{32{req.value[31]}}, req.value[31:0]};
        nbits = 7'd32;
      end
      ARG_CHAR: begin
        sx    = {{56{req.value[7]}}, req.value[7:0]};
        nbits = 7'd8;
      end
      ARG_SHORT: begin
        sx    = {{48{req.value[15]}}, req.value[15:0]};
        nbits = 7'd16;
      end
      default: begin
        sx    = req.value;
        nbits = 7'd64;
      end
    endcase
    mag = sx[63] ? (64'd0 - sx) : sx;
    unique case (req.arg_size)
      ARG_INT:   mag_al = {mag[31:0], 32'd0};
      ARG_CHAR:  mag_al = {mag[7:0], 56'd0};
      ARG_SHORT: mag_al = {mag[15:0], 48'd0};
      default:   mag_al = mag;
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? (bcd[i] + 4'd3) : bcd[i];
    end
    dn[0] = {adj[0][2:0], mag_sr[63]};
    for (int i = 1; i < MAX_DIGITS; i++) begin
      dn[i] = {adj[i][2:0], adj[i-1][3]};
    end
    ndig_inc = (ndig < DIG_W'(MAX_DIGITS)) && (dn[ndig] != 4'd0);
  end

  always_comb begin
    d_cnt = (ndig == '0 && !(pgiven && prec == 6'd0)) ? DIG_W'(1) : ndig;
    d_pz  = (pgiven && prec > 6'(d_cnt)) ? (prec - 6'(d_cnt)) : 6'd0;
  end

  always_comb begin
    body = 8'(dcnt) + 8'(pz) + 8'(has_sign);
    pad  = ({1'b0, wsat} > body) ? ({1'b0, wsat} - body) : 8'd0;
    sum  = body + pad;
    s_e1 = (!left && !zf) ? pad : 8'd0;
    s_e2 = s_e1 + 8'(has_sign);
    s_e3 = s_e2 + (zf ? pad : 8'd0) + 8'(pz);
  end

  always_comb begin
    pos8  = {1'b0, pos};
    didx8 = e4 - 8'd1 - pos8;
    priority if (pos8 < e1) begin
      ch = CH_SPACE;
    end else if (pos8 < e2) begin
      ch = sign_ch;
    end else if (pos8 < e3) begin
      ch = CH_ZERO;
    end else if (pos8 < e4) begin
      ch = CH_ZERO + {4'd0, bcd[didx8[DIG_W-1:0]]};
    end else begin
      ch = CH_SPACE;
    end
  end

  assign sts.conv_done = (cnt == 7'd0);
  assign sts.out_free  = !m_valid_q || m_tready;
  assign sts.emit_last = (total == 7'd0) || ((pos + 7'd1) == total);

  always_ff @(posedge clk) begin
    if (rst) begin
      ndig <= '0;
    end else if (cmd.load) begin
      ndig <= '0;
    end else if (cmd.shift) begin
      ndig <= ndig + DIG_W'(ndig_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_sr <= mag_al;
      cnt    <= nbits;
      neg    <= sx[63];
      pgiven <= req.precision_given;
      prec   <= req.precision;
      zpad   <= req.zero_pad;
      left   <= req.align_left;
      smode  <= req.sign_mode;
      width  <= req.width;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        bcd[i] <= 4'd0;
      end
    end else if (cmd.shift) begin
      mag_sr <= {mag_sr[62:0], 1'b0};
      cnt    <= cnt - 7'd1;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        bcd[i] <= dn[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      dcnt     <= d_cnt;
      pz       <= d_pz;
      has_sign <= neg || smode == SIGN_PLUS || smode == SIGN_SPACE;
      if (neg) begin
        sign_ch <= CH_MINUS;
      end else if (smode == SIGN_PLUS) begin
        sign_ch <= CH_PLUS;
      end else begin
        sign_ch <= CH_SPACE;
      end
      wsat <= (width > FIELD7) ? FIELD7 : width;
      zf   <= zpad && !pgiven && !left;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.span) begin
      total <= (sum > FIELD8) ? FIELD7 : sum[6:0];
      e1    <= s_e1;
      e2    <= s_e2;
      e3    <= s_e3;
      e4    <= s_e3 + 8'(dcnt);
      pos   <= 7'd0;
    end else if (cmd.emit) begin
      pos <= pos + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char  <= (total == 7'd0) ? CH_NUL : ch;
      out_flag  <= (total != 7'd0);
      out_last  <= sts.emit_last;
      out_total <= total;
    end
  end

  assign m_tvalid = m_valid_q;
  assign m_tdata  = {1'b0, out_total, out_char};
  assign m_tlast  = out_last;
  assign m_tuser  = out_flag;

`ifndef ASSERT_OFF
  a_ndig_bound: assert property (@(posedge clk) disable iff (rst)
    ndig <= DIG_W'(MAX_DIGITS))
    else $error("digit count beyond digit store");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_valid_q || m_tready))
    else $error("character loaded over an untaken transfer");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (pos < FIELD7))
    else $error("character position beyond field limit");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && sts.emit_last) |=> !cmd.emit)
    else $error("character emitted after last of field");
`endif

endmodule

// ===== rtl/core/signed_decimal_field_formatter.sv =====
// Signed decimal field formatter.
// Input channel s_*: one transfer carries a 64-bit argument and its printf
// flags; the block answers with one output transfer per ASCII character of
// the formatted field, tlast on the final one, every transfer also carrying
// the total field length. An empty field gives a single transfer with
// tuser (char_valid) low.
// Timing: after the input transfer the magnitude is converted by a shift
// and add-3 sequence, one bit per cycle, over as many bits as the argument
// size has (8, 16, 32 or 64); a status step ends the conversion, the field
// layout is then planned and spanned, and then one character per cycle
// follows while the receiver is ready.
// s_tready is high only between items; the last character may still wait in
// the output register while the next item is taken.
// A stalled receiver (m_tready low) holds the current character and stops
// the character sequence until it is taken.
// Reset (rst, synchronous) returns the sequencer to idle and drops any
// pending output transfer.
module signed_decimal_field_formatter
  import sdff_pkg::*;
#(
  parameter int MAX_FIELD = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // value[63:0], width[70:64], precision_given[71], precision[77:72],
  // zero_pad[78], align_left[79], sign_mode[81:80], zeros[87:82]
  input  logic [87:0] s_tdata,
  // arg_size[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // char_code[7:0], total_length[14:8], zero[15]
  output logic [15:0] m_tdata,
  output logic        m_tlast,
  // char_valid[0]
  output logic        m_tuser
);

  req_t req;
  cmd_t cmd;
  sts_t sts;

  assign req.value           = s_tdata[63:0];
  assign req.arg_size        = s_tuser;
  assign req.width           = s_tdata[70:64];
  assign req.precision_given = s_tdata[71];
  assign req.precision       = s_tdata[77:72];
  assign req.zero_pad        = s_tdata[78];
  assign req.align_left      = s_tdata[79];
  assign req.sign_mode       = s_tdata[81:80];

  sdff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sdff_datapath #(
    .MAX_FIELD (MAX_FIELD)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cmd      (cmd),
    .sts      (sts),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
